[design/rrc_pkg.sv]
package rrc_pkg;

  // Field and register widths
  localparam int unsigned SampleW       = 16;
  localparam int unsigned RatioW        = 32;
  localparam int unsigned ThreshW       = 16;
  localparam int unsigned CfgIdxW       = 3;
  localparam int unsigned CfgDataW      = 32;
  localparam int unsigned FieldChannels = 2;

  // Ratio of 1.0 in unsigned Q8.24
  localparam logic [RatioW-1:0] RatioOne = 32'd16777216;

  // Quotient bits produced by the divider, one per step
  localparam int unsigned DivSteps = 16;
  localparam int unsigned DivCntW  = $clog2(DivSteps);

  // Configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    CFG_THRESHOLD = 3'd0,
    CFG_TARGET    = 3'd1,
    CFG_ATTACK    = 3'd2,
    CFG_RELEASE   = 3'd3,
    CFG_SIDECHAIN = 3'd4
  } cfg_reg_e;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic in_load;
    logic ratio_update;
    logic div_init;
    logic div_step;
    logic res_write;
    logic chan;
    logic out_load;
  } dp_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic div_last;
  } dp_stat_t;

endpackage

[design/rrc_datapath.sv]
module rrc_datapath import rrc_pkg::*; #(
  parameter int unsigned NumDiv = 2
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  input  logic [47:0]         in_data_i,
  input  dp_cmd_t             cmd_i,
  output dp_stat_t            stat_o,
  output logic [31:0]         out_data_o
);

  logic [ThreshW-1:0]      thresh_q;
  logic [RatioW-1:0]       target_q;
  logic [RatioW-1:0]       attack_q;
  logic [RatioW-1:0]       release_q;
  logic                    side_q;
  logic [RatioW-1:0]       gain_q, gain_d;
  logic signed [SampleW-1:0] s0_q, s1_q, sc_q;
  logic [RatioW-1:0]       rem_q, rem_d;
  logic [SampleW-1:0]      quo_q, quo_d;
  logic                    neg_q;
  logic [DivCntW-1:0]      cnt_q;
  logic [SampleW-1:0]      res0_q, res1_q;
  logic [SampleW-1:0]      out0_q, out1_q;

  logic signed [SampleW-1:0] det_smp, div_smp;
  logic [SampleW:0]        det_mag, div_mag;
  logic [RatioW:0]         att_sum, rem_sh;
  logic                    rem_ge;
  logic [SampleW-1:0]      quo_signed;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thresh_q  <= 16'd32768;
      target_q  <= RatioOne;
      attack_q  <= '0;
      release_q <= '0;
      side_q    <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_THRESHOLD: thresh_q  <= cfg_data_i[ThreshW-1:0];
        CFG_TARGET:    target_q  <= cfg_data_i[RatioW-1:0];
        CFG_ATTACK:    attack_q  <= cfg_data_i[RatioW-1:0];
        CFG_RELEASE:   release_q <= cfg_data_i[RatioW-1:0];
        CFG_SIDECHAIN: side_q    <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // Detector magnitude; the most negative sample gives 32768.
  assign det_smp = side_q ? sc_q : s0_q;
  assign det_mag = det_smp[SampleW-1] ? (17'h10000 - {1'b0, det_smp})
                                      : {1'b0, det_smp};

  // Ratio ramp: attack toward the target, release toward 1.0
  assign att_sum = {1'b0, gain_q} + {1'b0, attack_q};
  always_comb begin
    gain_d = gain_q;
    if (det_mag > {1'b0, thresh_q}) begin
      if (gain_q < target_q) begin
        gain_d = (att_sum > {1'b0, target_q}) ? target_q : att_sum[RatioW-1:0];
      end
    end else if (gain_q > RatioOne) begin
      gain_d = (release_q >= gain_q - RatioOne) ? RatioOne : gain_q - release_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_q <= RatioOne;
    end else if (cmd_i.ratio_update) begin
      gain_q <= gain_d;
    end
  end

  // Frame samples, held for the whole item
  always_ff @(posedge clk_i) begin
    if (cmd_i.in_load) begin
      s0_q <= in_data_i[15:0];
      s1_q <= in_data_i[31:16];
      sc_q <= in_data_i[47:32];
    end
  end

  // Restoring divider: the partial remainder stays below the ratio, so
  // (magnitude << 24) / ratio fits in 16 quotient bits.
  assign div_smp = cmd_i.chan ? s1_q : s0_q;
  assign div_mag = div_smp[SampleW-1] ? (17'h10000 - {1'b0, div_smp})
                                      : {1'b0, div_smp};
  assign rem_sh  = {rem_q, 1'b0};
  assign rem_ge  = rem_sh >= {1'b0, gain_q};
  assign rem_d   = rem_ge ? 32'(rem_sh - {1'b0, gain_q}) : rem_sh[RatioW-1:0];
  assign quo_d   = {quo_q[SampleW-2:0], rem_ge};
  assign quo_signed = neg_q ? 16'(16'd0 - quo_d) : quo_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (cmd_i.div_init) begin
      cnt_q <= '0;
    end else if (cmd_i.div_step) begin
      cnt_q <= cnt_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_init) begin
      rem_q <= {8'd0, div_mag[SampleW-1:0], 8'd0};
      quo_q <= '0;
      neg_q <= div_smp[SampleW-1];
    end else if (cmd_i.div_step) begin
      rem_q <= rem_d;
      quo_q <= quo_d;
    end
  end

  assign stat_o.div_last = (cnt_q == DivCntW'(DivSteps - 1));

  // Per-channel results, then the output register
  always_ff @(posedge clk_i) begin
    if (cmd_i.res_write) begin
      if (cmd_i.chan) begin
        res1_q <= quo_signed;
      end else begin
        res0_q <= quo_signed;
      end
    end
    if (cmd_i.out_load) begin
      out0_q <= res0_q;
      out1_q <= (NumDiv > 1) ? res1_q : '0;
    end
  end

  assign out_data_o = {out1_q, out0_q};

  // The ratio never drops below 1.0.
  a_gain_floor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    gain_q >= RatioOne)
    else $error("gain ratio below 1.0");

  // The ratio moves only on an update command.
  a_gain_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !cmd_i.ratio_update |=> $stable(gain_q))
    else $error("gain ratio changed without update");

endmodule

[design/rrc_ctrl.sv]
module rrc_ctrl import rrc_pkg::*; #(
  parameter int unsigned NumDiv = 2
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  input  dp_stat_t stat_i,
  output dp_cmd_t  cmd_o
);

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_RATIO = 5'b00010,
    ST_INIT  = 5'b00100,
    ST_STEP  = 5'b01000,
    ST_DONE  = 5'b10000
  } state_e;

  localparam logic LastChan = 1'(NumDiv - 1);

  state_e state_q, state_d;
  logic   chan_q, chan_d;
  logic   ovalid_q, ovalid_d;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = ovalid_q;

  // Sequencing of one frame: ratio update, then one division per channel
  always_comb begin
    state_d  = state_q;
    chan_d   = chan_q;
    ovalid_d = ovalid_q && !out_ready_i;
    cmd_o    = '0;
    cmd_o.chan = chan_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.in_load = 1'b1;
          state_d       = ST_RATIO;
        end
      end
      ST_RATIO: begin
        cmd_o.ratio_update = 1'b1;
        chan_d             = 1'b0;
        state_d            = ST_INIT;
      end
      ST_INIT: begin
        cmd_o.div_init = 1'b1;
        state_d        = ST_STEP;
      end
      ST_STEP: begin
        cmd_o.div_step = 1'b1;
        if (stat_i.div_last) begin
          cmd_o.res_write = 1'b1;
          if (chan_q == LastChan) begin
            state_d = ST_DONE;
          end else begin
            chan_d  = 1'b1;
            state_d = ST_INIT;
          end
        end
      end
      ST_DONE: begin
        // Wait until the output register is free or being drained.
        if (!ovalid_q || out_ready_i) begin
          cmd_o.out_load = 1'b1;
          ovalid_d       = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      chan_q   <= 1'b0;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      chan_q   <= chan_d;
      ovalid_q <= ovalid_d;
    end
  end

  // A loaded result is presented in the next cycle.
  a_load_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_load |=> ovalid_q)
    else $error("result loaded but not presented");

  // The divider runs its full count before leaving the step state.
  a_step_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_STEP && !stat_i.div_last) |=> (state_q == ST_STEP))
    else $error("division left early");

  // No new frame while a division is under way.
  a_no_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_STEP || state_q == ST_INIT) |-> !in_ready_o)
    else $error("input ready during division");

endmodule

[design/ramped_ratio_compressor_unit.sv]
// Ramped-ratio compressor: takes one stereo frame (plus a sidechain sample)
// per transfer, ramps the Q8.24 gain ratio up or down by the programmed steps
// depending on the detector level, and returns each channel divided by the
// new ratio, truncated toward zero. Frames are handled one at a time: an
// accepted frame goes through the ratio update and then one division per
// channel, for N = min(CHANNELS, 2) divided channels, and the unit is ready
// for the next once the result has entered the output register. The single
// shared divider yields one quotient bit per cycle. A finished result waits
// in an output register, so the next frame is taken while it is unclaimed.
// Configuration writes are meant for idle periods only.
module ramped_ratio_compressor_unit import rrc_pkg::*; #(
  parameter int unsigned CHANNELS = 2
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // Input frame transfer
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  // tdata: chan0_sample [15:0], chan1_sample [31:16], sidechain_sample [47:32]
  input  logic [47:0]         s_axis_tdata,
  // Result transfer
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // tdata: chan0_out [15:0], chan1_out [31:16]
  output logic [31:0]         m_axis_tdata,
  // Configuration write port
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  localparam int unsigned NumDiv = (CHANNELS < FieldChannels) ? CHANNELS : FieldChannels;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  // Sequencer
  rrc_ctrl #(
    .NumDiv(NumDiv)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .out_valid_o(m_axis_tvalid),
    .out_ready_i(m_axis_tready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  // Ratio ramp, divider and result registers
  rrc_datapath #(
    .NumDiv(NumDiv)
  ) u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i),
    .in_data_i  (s_axis_tdata),
    .cmd_i      (cmd),
    .stat_o     (stat),
    .out_data_o (m_axis_tdata)
  );

endmodule
